// File: hw/rtl/stbs_pkg.sv
// Shared types, codes and sizes for the sorted table binary search unit.
package stbs_pkg;

    localparam int SLOT_W  = 10;
    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 11;
    localparam int CMP_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic VAR_THREE_WAY   = 1'b0;
    localparam logic VAR_LOWER_BOUND = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] position;
        logic [CMP_W-1:0]  comparisons;
    } t_result;

    typedef struct packed {
        logic              variant;
        logic [SIZE_W-1:0] size;
    } t_cfg;

    // classified operation handed from the front to the back
    typedef struct packed {
        logic                      is_search;
        logic                      variant;
        logic [SIZE_W-1:0]         size;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// File: hw/rtl/stbs_front.sv
// Front end: config registers, item accept, classification into operations.
module stbs_front #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  stbs_pkg::t_cmd                   i_cmd,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stbs_pkg::SIZE_W-1:0]      i_cfg_data,
    input  stbs_pkg::t_queue_status          i_qstat,
    output logic                             o_push,
    output stbs_pkg::t_op                    o_op
);

    stbs_pkg::t_cfg r_cfg;
    logic           accept;
    logic           slot_ok;

    assign o_cfg_ready = 1'b1;
    assign busy        = i_qstat.full;
    assign accept      = start && !i_qstat.full;
    assign slot_ok     = 32'(i_cmd.slot) < TABLE_DEPTH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.variant <= stbs_pkg::VAR_THREE_WAY;
            r_cfg.size    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stbs_pkg::CFG_VARIANT: r_cfg.variant <= i_cfg_data[0];
                stbs_pkg::CFG_SIZE:    r_cfg.size    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // drop writes beyond the table; snapshot config into each search
    always_comb begin
        o_push         = accept && (i_cmd.kind == stbs_pkg::KIND_SEARCH || slot_ok);
        o_op.is_search = i_cmd.kind == stbs_pkg::KIND_SEARCH;
        o_op.variant   = r_cfg.variant;
        o_op.size      = (32'(r_cfg.size) > TABLE_DEPTH) ?
                         stbs_pkg::SIZE_W'(TABLE_DEPTH) : r_cfg.size;
        o_op.slot      = i_cmd.slot;
        o_op.value     = i_cmd.value;
    end

endmodule

// File: hw/rtl/stbs_queue.sv
// Short operation queue between the front end and the search engine.
module stbs_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  stbs_pkg::t_op           i_op,
    input  logic                    i_pop,
    output stbs_pkg::t_op           o_op,
    output stbs_pkg::t_queue_status o_stat
);

    localparam int QD  = stbs_pkg::QUEUE_DEPTH;
    localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW  = $clog2(QD + 1);

    stbs_pkg::t_op r_slots [QD];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = r_count == CW'(QD);
    assign o_stat.empty = r_count == '0;
    assign o_op         = r_slots[r_rptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(QD - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(QD - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wptr] <= i_op;
        end
    end

endmodule

// File: hw/rtl/stbs_back.sv
// Search engine: table memory, halving loop over one read port, result register.
module stbs_back #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  stbs_pkg::t_op           i_op,
    input  stbs_pkg::t_queue_status i_qstat,
    output logic                    o_pop,
    output logic                    o_result_valid,
    output stbs_pkg::t_result       o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = stbs_pkg::SIZE_W;
    localparam int KW = stbs_pkg::CMP_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    logic signed [stbs_pkg::VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [stbs_pkg::VALUE_W-1:0] r_rdata;

    t_state                              r_state, n_state;
    logic [SW-1:0]                       r_lo, n_lo;
    logic [SW-1:0]                       r_hi, n_hi;   // exclusive end for three-way
    logic [SW-1:0]                       r_mid, n_mid;
    logic signed [stbs_pkg::VALUE_W-1:0] r_key, n_key;
    logic                                r_var, n_var;
    logic [KW-1:0]                       r_cnt, n_cnt;
    logic                                r_res_valid, n_res_valid;
    stbs_pkg::t_result                   r_res, n_res;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          plan;
    logic          v_var;
    logic [SW-1:0] b_lo;
    logic [SW-1:0] b_hi;
    logic [SW:0]   sum;
    logic [SW-1:0] mid;
    logic [KW-1:0] cnt_base;
    logic [KW-1:0] cnt_inc;

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_var       = r_var;
        n_cnt       = r_cnt;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = AW'(r_mid);
        wr_en       = 1'b0;
        plan        = 1'b0;
        v_var       = r_var;
        b_lo        = r_lo;
        b_hi        = r_hi;
        cnt_base    = r_cnt;

        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    if (!i_op.is_search) begin
                        wr_en = 1'b1;
                    end else if (i_op.size == '0) begin
                        n_res_valid = 1'b1;
                        n_res       = '0;
                    end else begin
                        n_key    = i_op.value;
                        n_var    = i_op.variant;
                        v_var    = i_op.variant;
                        cnt_base = '0;
                        b_lo     = '0;
                        b_hi     = (i_op.variant == stbs_pkg::VAR_LOWER_BOUND) ?
                                   i_op.size - SW'(1) : i_op.size;
                        plan     = 1'b1;
                    end
                end
            end
            S_CMP: begin
                if (r_var == stbs_pkg::VAR_THREE_WAY && r_rdata == r_key) begin
                    n_res_valid          = 1'b1;
                    n_res.found          = 1'b1;
                    n_res.position       = stbs_pkg::SLOT_W'(r_mid);
                    n_res.comparisons    = r_cnt;
                    n_state              = S_IDLE;
                end else begin
                    if (r_rdata < r_key) begin
                        b_lo = r_mid + SW'(1);
                    end else begin
                        b_hi = r_mid;
                    end
                    plan = 1'b1;
                end
            end
            S_FINAL: begin
                n_res_valid       = 1'b1;
                n_res.found       = r_rdata == r_key;
                n_res.position    = (r_rdata == r_key) ? stbs_pkg::SLOT_W'(r_lo) : '0;
                n_res.comparisons = r_cnt;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next halving step from the new bounds: read the middle entry or finish
        sum     = {1'b0, b_lo} + {1'b0, b_hi}
                - {{SW{1'b0}}, v_var == stbs_pkg::VAR_THREE_WAY};
        mid     = sum[SW:1];
        cnt_inc = (cnt_base == '1) ? cnt_base : cnt_base + KW'(1);
        if (plan) begin
            n_lo = b_lo;
            n_hi = b_hi;
            if (b_lo < b_hi) begin
                rd_en   = 1'b1;
                rd_addr = AW'(mid);
                n_mid   = mid;
                n_cnt   = cnt_inc;
                n_state = S_CMP;
            end else if (v_var == stbs_pkg::VAR_LOWER_BOUND) begin
                rd_en   = 1'b1;
                rd_addr = AW'(b_lo);
                n_cnt   = cnt_inc;
                n_state = S_FINAL;
            end else begin
                n_res_valid       = 1'b1;
                n_res.found       = 1'b0;
                n_res.position    = '0;
                n_res.comparisons = cnt_base;
                n_state           = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(i_op.slot)] <= i_op.value;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_var <= n_var;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

endmodule

// File: hw/rtl/sorted_table_binary_search_unit.sv
// Top level of the sorted table binary search unit.
//
//   channel   | handshake                      | payload
//   ----------+--------------------------------+--------------------------------
//   command   | start in, busy out             | i_cmd    (kind, slot, value)
//   result    | o_result_valid strobe          | o_result (found, position, comparisons)
//   config    | i_cfg_valid in, o_cfg_ready out| i_cfg_index, i_cfg_data
//
// A command is taken at an edge with start high and busy low; busy is high while the
// two-entry operation queue is full. A search makes one table read per step
// (up to log2 of the size, rounded up, plus one reads, at most 11), paced by the single
// read port of the table memory and the compare-and-halve loop around it. Results
// appear as one-cycle strobes and cannot be stalled. Reset is synchronous and clears
// the queue, engine state and config; the table itself is not cleared.
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  stbs_pkg::t_cmd                 i_cmd,
    output logic                           o_result_valid,
    output stbs_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stbs_pkg::SIZE_W-1:0]    i_cfg_data
);

    stbs_pkg::t_queue_status qstat;
    stbs_pkg::t_op           push_op;
    stbs_pkg::t_op           head_op;
    logic                    push;
    logic                    pop;

    stbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_op        (push_op)
    );

    stbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_stat  (qstat)
    );

    stbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (head_op),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// File: hw/rtl/stbs_checker.sv
// Port-level checks for the sorted table binary search unit, bound to the top level.
module stbs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              busy,
    input logic              o_result_valid,
    input stbs_pkg::t_result o_result
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe right after reset");

    a_not_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy)
        else $error("busy right after reset");

    a_miss_position_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.found |-> o_result.position == '0)
        else $error("miss reported with nonzero position");

    a_hit_compared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.found |->
            o_result.comparisons != '0 && o_result.comparisons <= 4'd12)
        else $error("hit reported with impossible comparison count");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for the sorted table binary search unit.
`timescale 1ns / 1ps

module testbench;
    import stbs_pkg::*;

    localparam int DEPTH             = DEFAULT_TABLE_DEPTH;
    localparam int DRAIN_CYCLES      = 40;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int SMALL_STAGE_ITEMS = 820;
    localparam int CMP_MAX           = (1 << CMP_W) - 1;
    localparam int SIZE_MAX          = (1 << SIZE_W) - 1;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    typedef enum logic [1:0] {ROW_CMD, ROW_VARIANT, ROW_SIZE} t_row_op;

    typedef struct packed {
        t_row_op           op;
        t_cmd              cmd;
        logic [SIZE_W-1:0] cfg;
        logic              typed;
        t_result           res;
    } t_row;

    localparam int N_ROWS = 24;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   start          = 1'b0;
    logic                   busy;
    t_cmd                   i_cmd          = '0;
    logic                   o_result_valid;
    t_result                o_result;
    logic                   i_cfg_valid    = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [SIZE_W-1:0]      i_cfg_data     = '0;

    // testbench copy of the table and configuration
    logic signed [VALUE_W-1:0] entries [DEPTH];
    logic                      cur_variant = VAR_THREE_WAY;
    logic [SIZE_W-1:0]         cur_size    = '0;
    int                        loaded_len  = 0;

    t_result     pending_results [$];
    t_result     want;
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          searches_seen  = 0;
    int          cfg_writes     = 0;
    int unsigned cycle_count    = 0;
    bit          quiet          = 1'b0;

    // after reset: three-way search, empty table
    t_row directed_rows [N_ROWS] = '{
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, 32'sd0},      '0, 1'b1, '{1'b0, 10'd0, 4'd0}},
        '{ROW_VARIANT, '0, 11'(VAR_LOWER_BOUND),              1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, VALUE_MAX},   '0, 1'b1, '{1'b0, 10'd0, 4'd0}},
        '{ROW_CMD,     '{KIND_WRITE, 10'd0, VALUE_MIN},    '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_WRITE, 10'd1, -32'sd5},      '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_WRITE, 10'd2, 32'sd0},       '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_WRITE, 10'd3, 32'sd7},       '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_WRITE, 10'd4, VALUE_MAX},    '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_WRITE, 10'd1023, -32'sd1},   '0, 1'b0, '0},
        '{ROW_SIZE,    '0, 11'd5,                          1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, VALUE_MAX},   '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, VALUE_MIN},   '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, 32'sd3},      '0, 1'b0, '0},
        '{ROW_VARIANT, '0, 11'(VAR_THREE_WAY),                1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, 32'sd7},      '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd1023, VALUE_MIN},'0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, VALUE_MAX},   '0, 1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, 32'sd8},      '0, 1'b0, '0},
        '{ROW_SIZE,    '0, 11'd1,                          1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, VALUE_MIN},   '0, 1'b1, '{1'b1, 10'd0, 4'd1}},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, 32'sd0},      '0, 1'b1, '{1'b0, 10'd0, 4'd1}},
        '{ROW_VARIANT, '0, 11'(VAR_LOWER_BOUND),              1'b0, '0},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, VALUE_MIN},   '0, 1'b1, '{1'b1, 10'd0, 4'd1}},
        '{ROW_CMD,     '{KIND_SEARCH, 10'd0, VALUE_MAX},   '0, 1'b1, '{1'b0, 10'd0, 4'd1}}
    };

    sorted_table_binary_search_unit #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no search outstanding");
            end else begin
                want = pending_results.pop_front();
                searches_seen++;
                if (o_result.found !== want.found)
                    report_mismatch($sformatf("found %b, want %b",
                                              o_result.found, want.found));
                if (o_result.position !== want.position)
                    report_mismatch($sformatf("position %0d, want %0d",
                                              o_result.position, want.position));
                if (o_result.comparisons !== want.comparisons)
                    report_mismatch($sformatf("comparisons %0d, want %0d",
                                              o_result.comparisons, want.comparisons));
            end
        end
    end

    function automatic t_result search_table(input logic signed [VALUE_W-1:0] key);
        int          n;
        int          lo;
        int          hi;
        int          mid;
        int unsigned steps;
        t_result     r;
        r     = '0;
        steps = 0;
        n     = (cur_size > DEPTH) ? DEPTH : int'(cur_size);
        if (n == 0) return r;
        lo = 0;
        hi = n - 1;
        if (cur_variant == VAR_THREE_WAY) begin
            while (lo <= hi) begin
                steps++;
                mid = (lo + hi) / 2;
                if (entries[mid] == key) begin
                    r.found    = 1'b1;
                    r.position = SLOT_W'(mid);
                    break;
                end else if (entries[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
        end else begin
            // narrow to the first entry not below the key, then test it once
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                steps++;
                if (entries[mid] < key) lo = mid + 1;
                else hi = mid;
            end
            steps++;
            if (entries[lo] == key) begin
                r.found    = 1'b1;
                r.position = SLOT_W'(lo);
            end
        end
        r.comparisons = (steps > CMP_MAX) ? CMP_W'(CMP_MAX) : CMP_W'(steps);
        return r;
    endfunction

    function automatic t_cmd make_cmd(input logic kind, input int slot, input int value);
        t_cmd c;
        c.kind  = kind;
        c.slot  = SLOT_W'(slot);
        c.value = value;
        return c;
    endfunction

    task automatic send_item(input t_cmd c, input bit typed, input t_result typed_res);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (c.kind == KIND_WRITE)
            entries[c.slot] = c.value;
        else
            pending_results.push_back(typed ? typed_res : search_table(c.value));
    endtask

    // hold start low until every search has answered and trailing writes are done
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        drain();
        if ($urandom_range(0, 99) < 10) repeat ($urandom_range(1, 4)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == CFG_VARIANT) cur_variant = data[0];
        else cur_size = data;
    endtask

    task automatic set_config(input logic variant, input int size);
        write_reg(CFG_VARIANT, SIZE_W'(variant));
        write_reg(CFG_SIZE, SIZE_W'(size));
    endtask

    // fill slots 0..n-1; narrow value ranges force duplicate runs
    task automatic load_table(input int n, input bit sorted);
        int vals [$];
        bit narrow;
        int v;
        narrow = ($urandom_range(0, 3) == 0);
        v      = 0;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 11) == 0) begin
                // keep the previous value
            end else if ($urandom_range(0, 39) == 0) begin
                v = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
            end else if (narrow) begin
                v = int'($urandom_range(0, 60)) - 30;
            end else begin
                v = int'($urandom);
            end
            vals.push_back(v);
        end
        if (sorted) vals.sort();
        foreach (vals[i]) send_item(make_cmd(KIND_WRITE, i, vals[i]), 1'b0, '0);
        if (n > loaded_len) loaded_len = n;
    endtask

    function automatic int pick_key(input int n);
        int roll;
        int idx;
        roll = $urandom_range(0, 99);
        idx  = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (n > 0 && roll < 50) return entries[idx];
        if (n > 0 && roll < 70) return entries[idx] + ($urandom_range(0, 1) ? 1 : -1);
        if (roll < 80) return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        return int'($urandom);
    endfunction

    // searches over slots 0..n-1, with stray writes above the active range if allowed
    task automatic run_searches(input int count, input int n, input bit strays);
        for (int k = 0; k < count; k++) begin
            if (strays && n < DEPTH && $urandom_range(0, 9) == 0)
                send_item(make_cmd(KIND_WRITE, $urandom_range(n, DEPTH - 1), int'($urandom)),
                          1'b0, '0);
            else
                send_item(make_cmd(KIND_SEARCH, $urandom_range(0, DEPTH - 1), pick_key(n)),
                          1'b0, '0);
        end
    endtask

    initial begin
        int roll;
        int n;
        foreach (entries[i]) entries[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].op)
                ROW_CMD: begin
                    send_item(directed_rows[i].cmd, directed_rows[i].typed,
                              directed_rows[i].res);
                end
                ROW_VARIANT: begin
                    write_reg(CFG_VARIANT, directed_rows[i].cfg);
                end
                default: begin
                    write_reg(CFG_SIZE, directed_rows[i].cfg);
                end
            endcase
        end
        loaded_len = 5;

        // small tables, mostly sorted, reloaded often
        while (items_sent < SMALL_STAGE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) n = 0;
            else if (roll < 20) n = $urandom_range(1, 2);
            else if (roll < 80) n = $urandom_range(3, 32);
            else n = $urandom_range(33, 64);
            set_config($urandom_range(0, 1), n);
            if (n > loaded_len || $urandom_range(0, 2) != 0)
                load_table(n, $urandom_range(0, 7) != 0);
            run_searches($urandom_range(6, 18), n, 1'b1);
        end

        // full table, loaded back to back without gaps
        drain();
        quiet = 1'b1;
        load_table(DEPTH, 1'b1);
        quiet = 1'b0;
        for (int p = 0; p < 8; p++) begin
            if (p < 2) n = DEPTH;
            else if (p < 4) n = SIZE_MAX;
            else if (p == 4) n = $urandom_range(DEPTH + 1, SIZE_MAX - 1);
            else n = $urandom_range(2, DEPTH);
            set_config((p < 4) ? p[0] : $urandom_range(0, 1), n);
            run_searches(14, (n > DEPTH) ? DEPTH : n, 1'b0);
        end

        drain();
        $display("Sent %0d items and checked %0d search results across %0d register writes.",
                 items_sent, searches_seen, cfg_writes);
        $display("Covered both search variants, empty, small, full and oversized tables.");
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
